>>> hdl/sdinit_pkg.sv
// ----------------------------------------------------------------------------
// sdinit_pkg
// Types, codes and command framing for the SD card SPI-mode start-up
// sequencer.
// ----------------------------------------------------------------------------
package sdinit_pkg;

  localparam int CfgDataWidth = 10;
  localparam int CfgIdxWidth  = 2;

  localparam logic [CfgIdxWidth-1:0] REG_WAKE_BYTES    = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_POLL_LIMIT    = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_INIT_ATTEMPTS = 2'd2;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_XFER  = 1'b1;

  localparam logic [7:0] WAKE_BYTES_RST    = 8'd10;
  localparam logic [7:0] POLL_LIMIT_RST    = 8'd8;
  localparam logic [9:0] INIT_ATTEMPTS_RST = 10'd200;

  localparam logic [7:0]  IDLE_BYTE   = 8'hff;
  localparam logic [7:0]  CMD_PREFIX  = 8'h40;
  localparam logic [7:0]  CRC_CMD0    = 8'h95;
  localparam logic [7:0]  CRC_CMD8    = 8'h87;
  localparam logic [31:0] ARG_CMD8    = 32'h0000_01aa;
  localparam logic [31:0] ARG_HCS     = 32'h4000_0000;
  localparam logic [7:0]  R1_IDLE     = 8'h01;
  localparam logic [7:0]  R1_READY    = 8'h00;
  localparam logic [7:0]  FRAME_CRC_IDX = 8'd5;
  localparam logic [7:0]  DATA_BYTES  = 8'd4;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_CMD0_IDLE  = 3'd1,
    ST_CMD8_BAD   = 3'd2,
    ST_CMD8_IDLE  = 3'd3,
    ST_ECHO       = 3'd4,
    ST_CMD55_BAD  = 3'd5,
    ST_ACMD41_BAD = 3'd6,
    ST_NEVER_RDY  = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    CMD_GO  = 3'd0,
    CMD_IF  = 3'd1,
    CMD_APP = 3'd2,
    CMD_OP  = 3'd3,
    CMD_OCR = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_WAKE = 3'd1,
    PH_SEND = 3'd2,
    PH_POLL = 3'd3,
    PH_DATA = 3'd4,
    PH_TAIL = 3'd5
  } phase_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       chip_select;
    logic       done_res;
    logic [2:0] status;
    logic       sd_v2;
    logic       high_capacity;
    logic [7:0] fail_resp;
    logic       timed_out;
  } out_word_t;

  function automatic logic [7:0] frame_byte(cmd_t c, logic [2:0] idx, logic v2);
    logic [31:0] arg;
    logic [7:0]  crc;
    logic [7:0]  num;
    logic [7:0]  b;
    arg = '0;
    crc = '0;
    case (c)
      CMD_GO:  begin num = 8'd0;  crc = CRC_CMD0; end
      CMD_IF:  begin num = 8'd8;  arg = ARG_CMD8; crc = CRC_CMD8; end
      CMD_APP: num = 8'd55;
      CMD_OP:  begin num = 8'd41; if (v2) arg = ARG_HCS; end
      CMD_OCR: num = 8'd58;
      default: num = 8'd0;
    endcase
    case (idx)
      3'd0:    b = CMD_PREFIX | num;
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = crc;
    endcase
    return b;
  endfunction

endpackage

>>> hdl/sd_card_spi_init_sequencer.sv
// ----------------------------------------------------------------------------
// sd_card_spi_init_sequencer
// SD card SPI-mode start-up: wake bytes, CMD0, CMD8, CMD55/ACMD41 rounds and
// CMD58, one SPI byte exchange per input word.
// ----------------------------------------------------------------------------
// Each input word is either a start request or the report of one finished
// SPI byte exchange; the block answers with the next byte to send and its
// chip-select level, or with a final word carrying done, status, version,
// CCS and the failing response. An exchange word that arrives while no
// sequence runs is dropped without an answer. The decision logic sits
// between the input handshake and a single result register, so each answer
// is registered and a new word is accepted each cycle as long as answers
// are taken; while an answer waits in the result register for out_ready,
// in_ready stays low. Register writes take effect on the next word.
module sd_card_spi_init_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sdinit_pkg::in_word_t              in_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sdinit_pkg::out_word_t             out_word,
  input  logic                              cfg_wr_en,
  input  logic [sdinit_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  logic [sdinit_pkg::CfgDataWidth-1:0] cfg_data
);
  import sdinit_pkg::*;

  logic [7:0]  wake_bytes;
  logic [7:0]  poll_limit;
  logic [9:0]  init_attempts;

  phase_t      phase, phase_next;
  cmd_t        cmd, cmd_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  poll_count, poll_count_next;
  logic [9:0]  attempt_count, attempt_count_next;
  logic        version_two, version_two_next;
  logic        timeout_flag, timeout_flag_next;
  logic [7:0]  response_hold, response_hold_next;
  logic [31:0] reply_word, reply_word_next;

  logic        fire;
  logic        has_res;
  out_word_t   res;

  logic [7:0]  byte_inc;
  logic [7:0]  poll_base;
  logic        poll_open, poll_found, poll_wait, in_poll;
  logic        has_data, send_more, wake_more, data_last;

  logic        fin_done;
  status_t     fin_status;
  cmd_t        fin_cmd;
  logic        fin_v2;
  logic [9:0]  fin_att;
  logic        fin_ok;

  assign fire     = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wake_bytes    <= WAKE_BYTES_RST;
      poll_limit    <= POLL_LIMIT_RST;
      init_attempts <= INIT_ATTEMPTS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WAKE_BYTES:    wake_bytes    <= cfg_data[7:0];
        REG_POLL_LIMIT:    poll_limit    <= cfg_data[7:0];
        REG_INIT_ATTEMPTS: init_attempts <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // shared decisions
  always_comb begin
    byte_inc   = byte_count + 8'd1;
    poll_base  = (phase == PH_SEND) ? 8'd0 : poll_count;
    poll_open  = poll_base < poll_limit;
    poll_found = poll_open && !in_word.rx_byte[7];
    poll_wait  = poll_open && !poll_found;
    send_more  = byte_count < FRAME_CRC_IDX;
    in_poll    = ((phase == PH_SEND) && !send_more) || (phase == PH_POLL);
    has_data   = (cmd == CMD_IF) || (cmd == CMD_OCR);
    wake_more  = byte_count < wake_bytes;
    data_last  = byte_inc >= DATA_BYTES;
  end

  // end-of-command decode
  always_comb begin
    fin_done   = 1'b0;
    fin_status = ST_OK;
    fin_cmd    = cmd;
    fin_v2     = version_two;
    fin_att    = attempt_count;
    case (cmd)
      CMD_GO: begin
        if (timeout_flag || response_hold != R1_IDLE) begin
          fin_done   = 1'b1;
          fin_status = ST_CMD0_IDLE;
        end else begin
          fin_cmd = CMD_IF;
        end
      end
      CMD_IF: begin
        fin_cmd = CMD_APP;
        fin_att = '0;
        if (timeout_flag) begin
          fin_done   = 1'b1;
          fin_status = ST_CMD8_BAD;
        end else if (response_hold[2]) begin
          fin_v2 = 1'b0;
        end else if (response_hold[7:1] == 7'd0) begin
          fin_v2 = 1'b1;
          if (response_hold != R1_IDLE) begin
            fin_done   = 1'b1;
            fin_status = ST_CMD8_IDLE;
          end else if (reply_word[15:0] != ARG_CMD8[15:0]) begin
            fin_done   = 1'b1;
            fin_status = ST_ECHO;
          end
        end else begin
          fin_done   = 1'b1;
          fin_status = ST_CMD8_BAD;
        end
      end
      CMD_APP: begin
        if (timeout_flag || response_hold != R1_IDLE) begin
          fin_done   = 1'b1;
          fin_status = ST_CMD55_BAD;
        end else begin
          fin_cmd = CMD_OP;
        end
      end
      CMD_OP: begin
        if (!timeout_flag && response_hold == R1_IDLE) begin
          fin_att = attempt_count + 10'd1;
          if (fin_att < init_attempts) begin
            fin_cmd = CMD_APP;
          end else begin
            fin_done   = 1'b1;
            fin_status = ST_NEVER_RDY;
          end
        end else if (!timeout_flag && response_hold == R1_READY) begin
          fin_cmd = CMD_OCR;
        end else begin
          fin_done   = 1'b1;
          fin_status = ST_ACMD41_BAD;
        end
      end
      default: begin
        fin_done   = 1'b1;
        fin_status = ST_OK;
      end
    endcase
    fin_ok = (fin_status == ST_OK);
  end

  // next state
  always_comb begin
    phase_next = phase;
    cmd_next   = cmd;
    if (fire) begin
      if (in_word.func == FUNC_START) begin
        phase_next = PH_WAKE;
      end else begin
        case (phase)
          PH_IDLE: phase_next = PH_IDLE;
          PH_WAKE: begin
            if (!wake_more) begin
              phase_next = PH_SEND;
              cmd_next   = CMD_GO;
            end
          end
          PH_SEND, PH_POLL: begin
            if (in_poll) begin
              if (poll_wait)     phase_next = PH_POLL;
              else if (has_data) phase_next = PH_DATA;
              else               phase_next = PH_TAIL;
            end
          end
          PH_DATA: begin
            if (data_last) phase_next = PH_TAIL;
          end
          PH_TAIL: begin
            if (fin_done) begin
              phase_next = PH_IDLE;
            end else begin
              phase_next = PH_SEND;
              cmd_next   = fin_cmd;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // result word and datapath
  always_comb begin
    has_res             = 1'b0;
    res                 = '0;
    byte_count_next     = byte_count;
    poll_count_next     = poll_count;
    attempt_count_next  = attempt_count;
    version_two_next    = version_two;
    timeout_flag_next   = timeout_flag;
    response_hold_next  = response_hold;
    reply_word_next     = reply_word;
    if (fire) begin
      if (in_word.func == FUNC_START) begin
        attempt_count_next = '0;
        poll_count_next    = '0;
        version_two_next   = 1'b0;
        timeout_flag_next  = 1'b0;
        response_hold_next = '0;
        reply_word_next    = '0;
        byte_count_next    = 8'd1;
        has_res            = 1'b1;
        res.tx_valid       = 1'b1;
        res.tx_byte        = IDLE_BYTE;
        res.chip_select    = 1'b1;
      end else begin
        case (phase)
          PH_WAKE: begin
            has_res      = 1'b1;
            res.tx_valid = 1'b1;
            if (wake_more) begin
              byte_count_next = byte_inc;
              res.tx_byte     = IDLE_BYTE;
              res.chip_select = 1'b1;
            end else begin
              byte_count_next = '0;
              res.tx_byte     = frame_byte(CMD_GO, 3'd0, version_two);
            end
          end
          PH_SEND, PH_POLL: begin
            has_res      = 1'b1;
            res.tx_valid = 1'b1;
            if (!in_poll) begin
              byte_count_next = byte_inc;
              res.tx_byte     = frame_byte(cmd, byte_inc[2:0], version_two);
            end else begin
              res.tx_byte = IDLE_BYTE;
              if (poll_wait) begin
                poll_count_next = poll_base + 8'd1;
              end else begin
                poll_count_next    = poll_base;
                response_hold_next = in_word.rx_byte;
                timeout_flag_next  = !poll_found;
                if (has_data) begin
                  byte_count_next = '0;
                  reply_word_next = '0;
                end
              end
            end
          end
          PH_DATA: begin
            reply_word_next = {reply_word[23:0], in_word.rx_byte};
            byte_count_next = byte_inc;
            has_res         = 1'b1;
            res.tx_valid    = 1'b1;
            res.tx_byte     = IDLE_BYTE;
          end
          PH_TAIL: begin
            has_res            = 1'b1;
            version_two_next   = fin_v2;
            attempt_count_next = fin_att;
            if (fin_done) begin
              res.chip_select   = 1'b1;
              res.done_res      = 1'b1;
              res.status        = fin_status;
              res.sd_v2         = fin_v2;
              res.high_capacity = fin_ok && (reply_word[31:30] == 2'b11);
              res.fail_resp     = fin_ok ? 8'd0 : response_hold;
              res.timed_out     = !fin_ok && timeout_flag;
            end else begin
              byte_count_next = '0;
              res.tx_valid    = 1'b1;
              res.tx_byte     = frame_byte(fin_cmd, 3'd0, fin_v2);
            end
          end
          default: has_res = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      cmd           <= CMD_GO;
      byte_count    <= '0;
      poll_count    <= '0;
      attempt_count <= '0;
      version_two   <= 1'b0;
      timeout_flag  <= 1'b0;
      response_hold <= '0;
      reply_word    <= '0;
    end else begin
      phase         <= phase_next;
      cmd           <= cmd_next;
      byte_count    <= byte_count_next;
      poll_count    <= poll_count_next;
      attempt_count <= attempt_count_next;
      version_two   <= version_two_next;
      timeout_flag  <= timeout_flag_next;
      response_hold <= response_hold_next;
      reply_word    <= reply_word_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (fire && has_res) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_res) out_word <= res;
  end

  // a finished sequence always returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    fire && has_res && res.done_res |=> phase == PH_IDLE)
    else $error("done word did not return to idle");

  // chip select high only during wake bytes
  a_cs_wake: assert property (@(posedge clk) disable iff (rst)
    fire && has_res && res.tx_valid && res.chip_select |=> phase == PH_WAKE)
    else $error("chip select high outside wake phase");

  // command frame never runs past its crc byte
  a_frame_len: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SEND |-> byte_count <= FRAME_CRC_IDX)
    else $error("command frame too long");

  // success is only reported after the ocr read
  a_ok_ocr: assert property (@(posedge clk) disable iff (rst)
    fire && has_res && res.done_res && res.status == ST_OK |-> cmd == CMD_OCR)
    else $error("ok status before ocr read");

endmodule

>>> bench/sdinit_answer_monitor.sv
// ----------------------------------------------------------------------------
// sdinit_answer_monitor
// Watches the word channels and register writes of the SD card SPI-mode
// start-up sequencer, predicts the answer to each answered input word and
// compares each answered word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sdinit_answer_monitor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  sdinit_pkg::in_word_t                in_word,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  sdinit_pkg::out_word_t               out_word,
  input  logic                                cfg_wr_en,
  input  logic [sdinit_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  logic [sdinit_pkg::CfgDataWidth-1:0] cfg_data,
  output int                                  fail_count,
  output int                                  outstanding
);
  import sdinit_pkg::*;

  logic [7:0]  wake_n;
  logic [7:0]  poll_lim;
  logic [9:0]  attempts_max;
  phase_t      ph;
  cmd_t        cur;
  logic [7:0]  byte_cnt;
  logic [7:0]  poll_cnt;
  logic [9:0]  attempt_cnt;
  logic        v2;
  logic        to_flag;
  logic [7:0]  resp_hold;
  logic [31:0] reply_shift;
  bit          answered;
  out_word_t   due_answers[$];
  out_word_t   ans;
  out_word_t   want;

  function automatic logic [7:0] cmd_byte(cmd_t c, logic [7:0] i);
    logic [31:0] arg;
    logic [7:0]  crc;
    logic [5:0]  num;
    arg = '0;
    crc = '0;
    case (c)
      CMD_GO:  begin num = 6'd0; crc = CRC_CMD0; end
      CMD_IF:  begin num = 6'd8; arg = ARG_CMD8; crc = CRC_CMD8; end
      CMD_APP: num = 6'd55;
      CMD_OP:  begin num = 6'd41; arg = v2 ? ARG_HCS : 32'h0; end
      default: num = 6'd58;
    endcase
    if (i == 0) return CMD_PREFIX | {2'b00, num};
    if (i >= FRAME_CRC_IDX) return crc;
    return 8'(arg >> (8 * (4 - i)));
  endfunction

  function automatic out_word_t byte_out(logic [7:0] b, logic cs);
    out_word_t r;
    r = '0;
    r.tx_valid = 1'b1;
    r.tx_byte = b;
    r.chip_select = cs;
    return r;
  endfunction

  function automatic out_word_t end_out(status_t st);
    out_word_t r;
    logic      ok;
    ok = (st == ST_OK);
    r = '0;
    r.chip_select = 1'b1;
    r.done_res = 1'b1;
    r.status = st;
    r.sd_v2 = v2;
    r.high_capacity = ok && reply_shift[31:30] == 2'b11;
    r.fail_resp = ok ? 8'h00 : resp_hold;
    r.timed_out = !ok && to_flag;
    ph = PH_IDLE;
    return r;
  endfunction

  function automatic out_word_t begin_cmd(cmd_t c);
    ph = PH_SEND;
    cur = c;
    byte_cnt = '0;
    return byte_out(cmd_byte(c, 8'd0), 1'b0);
  endfunction

  function automatic out_word_t poll_step(logic [7:0] rx);
    logic hit;
    hit = poll_cnt < poll_lim && !rx[7];
    if (!hit && poll_cnt < poll_lim) begin
      poll_cnt++;
      return byte_out(IDLE_BYTE, 1'b0);
    end
    resp_hold = rx;
    to_flag = !hit;
    if (cur == CMD_IF || cur == CMD_OCR) begin
      ph = PH_DATA;
      byte_cnt = '0;
      reply_shift = '0;
    end else begin
      ph = PH_TAIL;
    end
    return byte_out(IDLE_BYTE, 1'b0);
  endfunction

  function automatic out_word_t close_cmd();
    case (cur)
      CMD_GO: begin
        if (to_flag || resp_hold != R1_IDLE) return end_out(ST_CMD0_IDLE);
        return begin_cmd(CMD_IF);
      end
      CMD_IF: begin
        if (to_flag) return end_out(ST_CMD8_BAD);
        if (resp_hold[2]) begin
          v2 = 1'b0;
        end else if (resp_hold[7:1] == 7'd0) begin
          v2 = 1'b1;
          if (resp_hold != R1_IDLE) return end_out(ST_CMD8_IDLE);
          if (reply_shift[15:0] != ARG_CMD8[15:0]) return end_out(ST_ECHO);
        end else begin
          return end_out(ST_CMD8_BAD);
        end
        attempt_cnt = '0;
        return begin_cmd(CMD_APP);
      end
      CMD_APP: begin
        if (to_flag || resp_hold != R1_IDLE) return end_out(ST_CMD55_BAD);
        return begin_cmd(CMD_OP);
      end
      CMD_OP: begin
        if (!to_flag && resp_hold == R1_IDLE) begin
          attempt_cnt++;
          if (attempt_cnt < attempts_max) return begin_cmd(CMD_APP);
          return end_out(ST_NEVER_RDY);
        end
        if (!to_flag && resp_hold == R1_READY) return begin_cmd(CMD_OCR);
        return end_out(ST_ACMD41_BAD);
      end
      default: return end_out(ST_OK);
    endcase
  endfunction

  function automatic out_word_t next_answer(in_word_t w);
    answered = 1'b1;
    if (w.func == FUNC_START) begin
      attempt_cnt = '0;
      poll_cnt = '0;
      v2 = 1'b0;
      to_flag = 1'b0;
      resp_hold = '0;
      reply_shift = '0;
      ph = PH_WAKE;
      byte_cnt = 8'd1;
      return byte_out(IDLE_BYTE, 1'b1);
    end
    case (ph)
      PH_WAKE: begin
        if (byte_cnt < wake_n) begin
          byte_cnt++;
          return byte_out(IDLE_BYTE, 1'b1);
        end
        return begin_cmd(CMD_GO);
      end
      PH_SEND: begin
        if (byte_cnt < FRAME_CRC_IDX) begin
          byte_cnt++;
          return byte_out(cmd_byte(cur, byte_cnt), 1'b0);
        end
        ph = PH_POLL;
        poll_cnt = '0;
        return poll_step(w.rx_byte);
      end
      PH_POLL: return poll_step(w.rx_byte);
      PH_DATA: begin
        reply_shift = {reply_shift[23:0], w.rx_byte};
        byte_cnt++;
        if (byte_cnt >= DATA_BYTES) ph = PH_TAIL;
        return byte_out(IDLE_BYTE, 1'b0);
      end
      PH_TAIL: return close_cmd();
      default: begin
        answered = 1'b0;
        return '0;
      end
    endcase
  endfunction

  task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, exp_val, got_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      wake_n = WAKE_BYTES_RST;
      poll_lim = POLL_LIMIT_RST;
      attempts_max = INIT_ATTEMPTS_RST;
      ph = PH_IDLE;
      cur = CMD_GO;
      byte_cnt = '0;
      poll_cnt = '0;
      attempt_cnt = '0;
      v2 = 1'b0;
      to_flag = 1'b0;
      resp_hold = '0;
      reply_shift = '0;
      due_answers.delete();
      fail_count = 0;
      outstanding = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_answers.size() == 0) begin
          $display("%0t: word with nothing expected, got %h", $time, out_word);
          fail_count++;
        end else begin
          want = due_answers.pop_front();
          check_field("tx_valid", 8'(want.tx_valid), 8'(out_word.tx_valid));
          check_field("tx_byte", want.tx_byte, out_word.tx_byte);
          check_field("chip_select", 8'(want.chip_select), 8'(out_word.chip_select));
          check_field("done_res", 8'(want.done_res), 8'(out_word.done_res));
          check_field("status", 8'(want.status), 8'(out_word.status));
          check_field("sd_v2", 8'(want.sd_v2), 8'(out_word.sd_v2));
          check_field("high_capacity", 8'(want.high_capacity),
                      8'(out_word.high_capacity));
          check_field("fail_resp", want.fail_resp, out_word.fail_resp);
          check_field("timed_out", 8'(want.timed_out), 8'(out_word.timed_out));
        end
      end
      if (in_valid && in_ready) begin
        ans = next_answer(in_word);
        if (answered) due_answers.push_back(ans);
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_WAKE_BYTES:    wake_n = cfg_data[7:0];
          REG_POLL_LIMIT:    poll_lim = cfg_data[7:0];
          REG_INIT_ATTEMPTS: attempts_max = cfg_data[9:0];
          default: ;
        endcase
      end
      outstanding = due_answers.size();
    end
  end

endmodule

>>> bench/sd_card_spi_init_sequencer_test.sv
// ----------------------------------------------------------------------------
// sd_card_spi_init_sequencer_test
// Drives the start-up sequencer with scripted card conversations (good v1
// and v2 cards, bad responses, timeouts, busy cards) plus truncated and
// corrupted sequences, over several register settings, with random gaps
// and stalls on both channels. The monitor predicts and checks every word.
// ----------------------------------------------------------------------------
module sd_card_spi_init_sequencer_test;
  import sdinit_pkg::*;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  in_word_t                in_word = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  out_word_t               out_word;
  logic                    cfg_wr_en = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;
  int                      fails;
  int                      pending;

  in_word_t feed[$];
  int       sent_n = 0;
  int       wake_cfg = WAKE_BYTES_RST;
  int       poll_cfg = POLL_LIMIT_RST;
  int       tries_cfg = INIT_ATTEMPTS_RST;
  bit       send_calm = 1'b0;

  sd_card_spi_init_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sdinit_answer_monitor u_monitor (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fails),
    .outstanding (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic push_word(logic f, logic [7:0] rx);
    in_word_t w;
    w.func = f;
    w.rx_byte = rx;
    feed.push_back(w);
  endtask

  // one command as seen from the card: frame bytes, polled r1, data, trailing byte
  task automatic card_reply(input logic [7:0] r1, input bit late, input int data_n,
                            input logic [31:0] data, output bit hit);
    int lag;
    int i;
    hit = !late && poll_cfg > 0;
    if (!hit) lag = poll_cfg;
    else if ($urandom_range(0, 7) == 0) lag = $urandom_range(0, poll_cfg - 1);
    else lag = $urandom_range(0, (poll_cfg > 3) ? 2 : poll_cfg - 1);
    repeat (5) push_word(FUNC_XFER, 8'($urandom));
    for (i = 0; i < lag; i++) push_word(FUNC_XFER, 8'h80 | 8'($urandom));
    push_word(FUNC_XFER, hit ? r1 : 8'($urandom));
    for (i = 0; i < data_n; i++) push_word(FUNC_XFER, data[31 - 8 * i -: 8]);
    push_word(FUNC_XFER, 8'($urandom));
  endtask

  task automatic build_session();
    int          k;
    int          busy;
    int          tries;
    int          pick;
    bit          hit;
    logic [7:0]  r1;
    logic [31:0] echo;
    if ($urandom_range(0, 9) == 0) push_word(FUNC_XFER, 8'($urandom));
    push_word(FUNC_START, 8'($urandom));
    repeat ((wake_cfg == 0) ? 1 : wake_cfg) push_word(FUNC_XFER, 8'($urandom));
    // cmd0
    pick = $urandom_range(0, 19);
    r1 = R1_IDLE;
    if (pick == 1) r1 = R1_READY;
    if (pick == 2) r1 = 8'($urandom) & 8'h7f;
    card_reply(r1, pick == 0, 0, '0, hit);
    if (!hit || r1 != R1_IDLE) return;
    // cmd8
    pick = $urandom_range(0, 9);
    echo = {16'($urandom), ARG_CMD8[15:0]};
    case (pick)
      4, 5:    r1 = 8'h04 | (8'($urandom) & 8'h7b);
      6:       begin r1 = R1_IDLE; echo = 32'($urandom); end
      7:       r1 = R1_READY;
      8:       r1 = 8'h08 | (8'($urandom) & 8'h7b);
      default: r1 = R1_IDLE;
    endcase
    card_reply(r1, pick == 9, 4, echo, hit);
    if (!hit || !(r1[2] || (r1 == R1_IDLE && echo[15:0] == ARG_CMD8[15:0]))) return;
    // cmd55 / acmd41 rounds
    tries = (tries_cfg == 0) ? 1 : tries_cfg;
    busy = $urandom_range(0, 3);
    if (tries <= 8 && $urandom_range(0, 5) == 0) busy = tries;
    for (k = 0; k < tries; k++) begin
      pick = $urandom_range(0, 39);
      card_reply((pick == 0) ? R1_READY : R1_IDLE, pick == 1, 0, '0, hit);
      if (!hit || pick == 0) return;
      pick = $urandom_range(0, 39);
      r1 = (k < busy) ? R1_IDLE : R1_READY;
      if (pick == 0) r1 = 8'h02 | (8'($urandom) & 8'h7c);
      card_reply(r1, pick == 1, 0, '0, hit);
      if (!hit || r1 != R1_IDLE) break;
    end
    if (!hit || r1 != R1_READY) return;
    // cmd58
    card_reply(8'($urandom) & 8'h7f, $urandom_range(0, 7) == 0, 4, 32'($urandom), hit);
  endtask

  task automatic send_words();
    in_word_t w;
    int       gap;
    while (feed.size() != 0) begin
      w = feed.pop_front();
      if ($urandom_range(0, 24) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_word <= w;
      do @(posedge clk); while (!in_ready);
      sent_n++;
    end
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(int wake, int poll, int tries);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_WAKE_BYTES;
    cfg_data <= CfgDataWidth'(wake);
    @(posedge clk);
    cfg_index <= REG_POLL_LIMIT;
    cfg_data <= CfgDataWidth'(poll);
    @(posedge clk);
    cfg_index <= REG_INIT_ATTEMPTS;
    cfg_data <= CfgDataWidth'(tries);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    wake_cfg = wake;
    poll_cfg = poll;
    tries_cfg = tries;
  endtask

  initial begin : drain_side
    int stall;
    int taken;
    bit calm;
    taken = 0;
    calm = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 24) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 14);
      if (taken % 250 == 40) stall = 90;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : stimulus
    bit       hit;
    int       phase_no;
    int       mark;
    int       cut;
    int       k;
    in_word_t w;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle exchanges, start, restart while running, cmd0 not idle
    push_word(FUNC_XFER, 8'h00);
    push_word(FUNC_XFER, 8'hff);
    push_word(FUNC_START, 8'h00);
    push_word(FUNC_XFER, 8'hff);
    push_word(FUNC_XFER, 8'h80);
    push_word(FUNC_START, 8'hff);
    repeat (WAKE_BYTES_RST) push_word(FUNC_XFER, 8'h7f);
    card_reply(R1_READY, 1'b0, 0, '0, hit);
    send_words();

    phase_no = 0;
    while (sent_n < 680) begin
      if (phase_no > 0) begin
        settle();
        case (phase_no)
          1:       load_settings(1, 1, 1);
          2:       load_settings(0, 0, 0);
          3:       load_settings(255, 255, 1023);
          4:       load_settings(4, 3, 4);
          default: load_settings($urandom_range(1, 12), $urandom_range(0, 10),
                                 $urandom_range(1, 6));
        endcase
      end
      mark = sent_n;
      do begin
        build_session();
        if ($urandom_range(0, 7) == 0) begin
          cut = $urandom_range(1, feed.size());
          while (feed.size() > cut) void'(feed.pop_back());
        end
        if ($urandom_range(0, 7) == 0) begin
          k = $urandom_range(0, feed.size() - 1);
          w = feed[k];
          w.rx_byte = 8'($urandom);
          if ($urandom_range(0, 2) == 0) w.func = ~w.func;
          feed[k] = w;
        end
        if ($urandom_range(0, 9) == 0) settle();
        send_words();
      end while (phase_no != 3 && sent_n - mark < 90);
      phase_no++;
    end

    settle();
    repeat (10) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
hdl/sdinit_pkg.sv
hdl/sd_card_spi_init_sequencer.sv
bench/sdinit_answer_monitor.sv
bench/sd_card_spi_init_sequencer_test.sv
